/* rtl/bfsk_pkg.sv */
// shared constants, types and sine table for the bfsk correlation demodulator
package bfsk_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int PHASE_WIDTH     = 16;
    localparam int SINE_ADDR_BITS  = 10;
    localparam int MAX_WINDOW_BITS = 10;

    localparam int PHASE_STEP_WIDTH = 16;
    localparam int SPB_WIDTH        = 10;
    localparam int POS_COUNT_WIDTH  = 10;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH  = 1;

    localparam int SINE_WIDTH = 16;
    localparam int DIFF_WIDTH = SINE_WIDTH + 1;
    localparam int PROD_WIDTH = SAMPLE_WIDTH + DIFF_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + MAX_WINDOW_BITS;
    localparam int TAKEN_WIDTH = MAX_WINDOW_BITS + 1;
    localparam int WIN_CMP_WIDTH = (TAKEN_WIDTH > SPB_WIDTH) ? TAKEN_WIDTH : SPB_WIDTH;

    localparam int QIDX_WIDTH = SINE_ADDR_BITS - 2;
    localparam int QSTEPS     = 1 << QIDX_WIDTH;
    localparam int HIGH_TONE_MULT = 3;

    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = -64'sd693598680;
    localparam longint POLY_C5 = 64'sd85569300;
    localparam longint POLY_C7 = -64'sd5026990;
    localparam longint POLY_C9 = 64'sd172270;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_PHASE_STEP      = 1'b0,
        CFG_SAMPLES_PER_BIT = 1'b1
    } cfg_index_t;

    typedef logic [SINE_WIDTH-2:0] qsine_t;
    typedef logic [QSTEPS-1:0][SINE_WIDTH-2:0] qsine_tbl_t;

    // word from the reference generator to the correlator
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic signed [DIFF_WIDTH-1:0]   ref_diff;
    } ref_word_t;

    // first-quadrant sine, odd degree-9 polynomial in q2.30, rounded to q1.15
    function automatic longint quarter_sine(input longint x);
        longint t;
        longint t2;
        longint acc;
        t   = x << (30 - QIDX_WIDTH);
        t2  = (t * t) / Q30_ONE;
        acc = POLY_C9;
        acc = POLY_C7 + (acc * t2) / Q30_ONE;
        acc = POLY_C5 + (acc * t2) / Q30_ONE;
        acc = POLY_C3 + (acc * t2) / Q30_ONE;
        acc = POLY_C1 + (acc * t2) / Q30_ONE;
        acc = (acc * t) / Q30_ONE;
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 64'sd16384) / 64'sd32768;
        if (acc > 64'sd32767) begin
            acc = 64'sd32767;
        end
        return acc;
    endfunction

    function automatic qsine_tbl_t build_qsine_tbl();
        qsine_tbl_t tbl;
        tbl = '0;
        for (int i = 0; i < QSTEPS; i++) begin
            tbl[i] = qsine_t'(quarter_sine(longint'(i)));
        end
        return tbl;
    endfunction

    localparam qsine_tbl_t QSINE_TBL  = build_qsine_tbl();
    localparam qsine_t     QSINE_PEAK = qsine_t'(quarter_sine(longint'(QSTEPS)));

    // top address bits of the phase, zero filled when the phase is narrower
    function automatic logic [SINE_ADDR_BITS-1:0] sine_addr(input logic [PHASE_WIDTH-1:0] ph);
        logic [PHASE_WIDTH+SINE_ADDR_BITS-1:0] wide;
        wide = {ph, {SINE_ADDR_BITS{1'b0}}};
        return wide[PHASE_WIDTH+SINE_ADDR_BITS-1 -: SINE_ADDR_BITS];
    endfunction

    function automatic logic signed [SINE_WIDTH-1:0] sine_lookup(
        input logic [SINE_ADDR_BITS-1:0] addr
    );
        logic [1:0]            quad;
        logic [QIDX_WIDTH-1:0] idx;
        qsine_t                mag;
        logic signed [SINE_WIDTH-1:0] v;
        quad = addr[SINE_ADDR_BITS-1 -: 2];
        idx  = addr[QIDX_WIDTH-1:0];
        if (quad[0]) begin
            if (idx == '0) begin
                mag = QSINE_PEAK;
            end else begin
                mag = QSINE_TBL[QIDX_WIDTH'(0) - idx];
            end
        end else begin
            mag = QSINE_TBL[idx];
        end
        v = {1'b0, mag};
        return quad[1] ? -v : v;
    endfunction

endpackage

/* rtl/bfsk_ref_gen.sv */
// phase accumulator, input register and tone reference lookup
module bfsk_ref_gen (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [bfsk_pkg::PHASE_STEP_WIDTH-1:0] phase_step,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [bfsk_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                  ref_valid,
    input  logic                                  ref_ready,
    output bfsk_pkg::ref_word_t                   ref_word
);
    import bfsk_pkg::*;

    logic [PHASE_WIDTH-1:0]         tone_phase_reg, tone_phase_next;
    logic                           a_valid_reg, a_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] a_sample_reg;
    logic [PHASE_WIDTH-1:0]         a_phase_reg;
    logic                           b_valid_reg, b_valid_next;
    ref_word_t                      b_word_reg, b_word_next;

    logic                           a_ready;
    logic                           b_ready;
    logic                           s_fire;
    logic [PHASE_WIDTH-1:0]         high_phase;
    logic signed [SINE_WIDTH-1:0]   sin_lo;
    logic signed [SINE_WIDTH-1:0]   sin_hi;

    assign b_ready = !b_valid_reg || ref_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign s_fire  = s_valid && a_ready;

    assign tone_phase_next = s_fire ? tone_phase_reg + PHASE_WIDTH'(phase_step)
                                    : tone_phase_reg;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (b_ready) begin
            a_valid_next = 1'b0;
        end
    end

    // high tone at three times the low tone phase
    assign high_phase = PHASE_WIDTH'(a_phase_reg * HIGH_TONE_MULT);
    assign sin_lo = sine_lookup(sine_addr(a_phase_reg));
    assign sin_hi = sine_lookup(sine_addr(high_phase));

    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;

    always_comb begin
        b_word_next = b_word_reg;
        if (b_ready) begin
            b_word_next.sample   = a_sample_reg;
            b_word_next.ref_diff = DIFF_WIDTH'(sin_hi) - DIFF_WIDTH'(sin_lo);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_phase_reg <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
        end else begin
            tone_phase_reg <= tone_phase_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_sample_reg <= s_sample;
            a_phase_reg  <= tone_phase_reg;
        end
        b_word_reg <= b_word_next;
    end

    assign ref_valid = b_valid_reg;
    assign ref_word  = b_word_reg;

endmodule

/* rtl/bfsk_correlator.sv */
// product stage, difference accumulator, window count and result register
module bfsk_correlator (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic [bfsk_pkg::SPB_WIDTH-1:0]            samples_per_bit,
    input  logic                                      ref_valid,
    output logic                                      ref_ready,
    input  bfsk_pkg::ref_word_t                       ref_word,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic                                      m_bit_value,
    output logic [bfsk_pkg::POS_COUNT_WIDTH-1:0]      m_positive_count
);
    import bfsk_pkg::*;

    logic                         c_valid_reg, c_valid_next;
    logic signed [PROD_WIDTH-1:0] c_prod_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg, acc_next;
    logic [MAX_WINDOW_BITS-1:0]   window_pos_reg, window_pos_next;
    logic [MAX_WINDOW_BITS-1:0]   tally_reg, tally_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_bit_reg, m_bit_next;
    logic [POS_COUNT_WIDTH-1:0]   m_count_reg, m_count_next;

    logic                         c_ready;
    logic                         d_ready;
    logic                         d_fire;
    logic signed [PROD_WIDTH-1:0] prod;
    logic signed [ACC_WIDTH-1:0]  sum;
    logic                         positive;
    logic [MAX_WINDOW_BITS-1:0]   tally_inc;
    logic [TAKEN_WIDTH-1:0]       taken;
    logic [WIN_CMP_WIDTH-1:0]     win_len;
    logic                         win_done;
    logic                         majority;

    assign prod = PROD_WIDTH'(ref_word.sample) * PROD_WIDTH'(ref_word.ref_diff);

    assign sum       = acc_reg + ACC_WIDTH'(c_prod_reg);
    assign positive  = !sum[ACC_WIDTH-1] && (sum != '0);
    assign tally_inc = tally_reg + MAX_WINDOW_BITS'(positive);
    assign taken     = TAKEN_WIDTH'(window_pos_reg) + TAKEN_WIDTH'(1);
    assign win_len   = (samples_per_bit == '0) ? WIN_CMP_WIDTH'(1)
                                               : WIN_CMP_WIDTH'(samples_per_bit);
    assign win_done  = WIN_CMP_WIDTH'(taken) >= win_len;
    assign majority  = {tally_inc, 1'b0} > taken;

    // only a finishing word needs room in the result register
    assign d_ready   = !(win_done && m_valid_reg && !m_ready);
    assign d_fire    = c_valid_reg && d_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign ref_ready = c_ready;

    assign c_valid_next = c_ready ? ref_valid : c_valid_reg;

    always_comb begin
        acc_next        = acc_reg;
        window_pos_next = window_pos_reg;
        tally_next      = tally_reg;
        if (d_fire) begin
            if (win_done) begin
                acc_next        = '0;
                window_pos_next = '0;
                tally_next      = '0;
            end else begin
                acc_next        = sum;
                window_pos_next = taken[MAX_WINDOW_BITS-1:0];
                tally_next      = tally_inc;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_bit_next   = m_bit_reg;
        m_count_next = m_count_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (d_fire && win_done) begin
            m_valid_next = 1'b1;
            m_bit_next   = majority;
            m_count_next = POS_COUNT_WIDTH'(tally_inc);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg    <= 1'b0;
            acc_reg        <= '0;
            window_pos_reg <= '0;
            tally_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            c_valid_reg    <= c_valid_next;
            acc_reg        <= acc_next;
            window_pos_reg <= window_pos_next;
            tally_reg      <= tally_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready) begin
            c_prod_reg <= prod;
        end
        m_bit_reg   <= m_bit_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_bit_value      = m_bit_reg;
    assign m_positive_count = m_count_reg;

endmodule

/* rtl/bfsk_correlation_demodulator.sv */
// top level of the bfsk correlation demodulator with its configuration registers
//
// One signed sample word is taken per clock unless the pipeline stalls, and is
// correlated against a low and a high tone (three times the low phase) read
// from a quarter-wave sine table. Only the difference of the two correlations
// is kept, in one full-precision accumulator; its sign after each sample feeds
// a positive count. At the end of each window of samples_per_bit samples one
// result word leaves: the majority bit and the positive count. Sample words
// pass three register stages (input, tone lookup, product) and then update the
// accumulator and the result register at the same edge, so the sustained rate
// is one sample per cycle; the accumulate stage stalls only when a window ends
// while the previous result still waits to be taken. Configuration is written
// through cfg_wr_en, cfg_index and cfg_data while no sample is in flight; the
// block itself does not enforce this.
module bfsk_correlation_demodulator (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [bfsk_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [bfsk_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [bfsk_pkg::SAMPLE_WIDTH-1:0] s_sample,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic                                     m_bit_value,
    output logic [bfsk_pkg::POS_COUNT_WIDTH-1:0]     m_positive_count
);
    import bfsk_pkg::*;

    logic [PHASE_STEP_WIDTH-1:0] phase_step_reg, phase_step_next;
    logic [SPB_WIDTH-1:0]        spb_reg, spb_next;

    logic                        ref_valid;
    logic                        ref_ready;
    ref_word_t                   ref_word;

    always_comb begin
        phase_step_next = phase_step_reg;
        spb_next        = spb_reg;
        if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_STEP: begin
                    phase_step_next = PHASE_STEP_WIDTH'(cfg_data);
                end
                CFG_SAMPLES_PER_BIT: begin
                    spb_next = SPB_WIDTH'(cfg_data);
                end
                default: begin
                    phase_step_next = phase_step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= PHASE_STEP_WIDTH'(655);
            spb_reg        <= SPB_WIDTH'(100);
        end else begin
            phase_step_reg <= phase_step_next;
            spb_reg        <= spb_next;
        end
    end

    bfsk_ref_gen u_ref_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .phase_step (phase_step_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .ref_valid  (ref_valid),
        .ref_ready  (ref_ready),
        .ref_word   (ref_word)
    );

    bfsk_correlator u_correlator (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .samples_per_bit  (spb_reg),
        .ref_valid        (ref_valid),
        .ref_ready        (ref_ready),
        .ref_word         (ref_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bit_value      (m_bit_value),
        .m_positive_count (m_positive_count)
    );

endmodule

/* tb/bfsk_demod_checker.sv */
// checker for the bfsk demodulator: predicts each result word and compares it
module bfsk_demod_checker (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [bfsk_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [bfsk_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
    input  logic                                     s_valid,
    input  logic                                     s_ready,
    input  logic signed [bfsk_pkg::SAMPLE_WIDTH-1:0] s_sample,
    input  logic                                     m_valid,
    input  logic                                     m_ready,
    input  logic                                     m_bit_value,
    input  logic [bfsk_pkg::POS_COUNT_WIDTH-1:0]     m_positive_count,
    output int                                       words_pending,
    output int                                       mismatch_count
);

    localparam int     QUARTER    = 256;
    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint K1         = 64'sd1686629713;
    localparam longint K3         = -64'sd693598680;
    localparam longint K5         = 64'sd85569300;
    localparam longint K7         = -64'sd5026990;
    localparam longint K9         = 64'sd172270;
    localparam logic [15:0] STEP_AT_RESET = 16'd655;
    localparam logic [9:0]  SPAN_AT_RESET = 10'd100;

    typedef struct packed {
        logic       decision;
        logic [9:0] count;
    } bit_word_t;

    longint      qwave_tbl [0:QUARTER];
    bit_word_t   bits_due [$];
    logic [15:0] osc_phase;
    logic [15:0] step_reg;
    logic [9:0]  span_reg;
    longint      corr_low;
    longint      corr_high;
    int unsigned fill;
    int unsigned tally;
    int          fails = 0;
    int          due_depth = 0;

    assign mismatch_count = fails;
    assign words_pending  = due_depth;

    // first quadrant of the sine, odd polynomial in q2.30 rounded to q1.15
    function automatic longint quarter_wave(input int x);
        longint t;
        longint t2;
        longint acc;
        t   = longint'(x) << 22;
        t2  = (t * t) / ONE_Q30;
        acc = K9;
        acc = K7 + (acc * t2) / ONE_Q30;
        acc = K5 + (acc * t2) / ONE_Q30;
        acc = K3 + (acc * t2) / ONE_Q30;
        acc = K1 + (acc * t2) / ONE_Q30;
        acc = (acc * t) / ONE_Q30;
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + 64'sd16384) / 64'sd32768;
        if (acc > 64'sd32767) begin
            acc = 64'sd32767;
        end
        return acc;
    endfunction

    initial begin
        for (int i = 0; i <= QUARTER; i++) begin
            qwave_tbl[i] = quarter_wave(i);
        end
    end

    function automatic longint tone_at(input logic [15:0] ph);
        logic [9:0] addr;
        longint     mag;
        addr = ph[15:6];
        if (addr[8]) begin
            mag = qwave_tbl[QUARTER - int'(addr[7:0])];
        end else begin
            mag = qwave_tbl[int'(addr[7:0])];
        end
        return addr[9] ? -mag : mag;
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        $display("%0t bfsk checker: %s", $time, what);
    endtask

    task automatic take_sample(input logic signed [15:0] smp);
        longint      s;
        logic [15:0] triple;
        int unsigned taken;
        int unsigned span;
        bit_word_t   w;
        s      = longint'(smp);
        triple = osc_phase * 16'd3;
        corr_low  += s * tone_at(osc_phase);
        corr_high += s * tone_at(triple);
        osc_phase += step_reg;
        if (corr_high - corr_low > 0) begin
            tally = (tally + 1) & 32'h3ff;
        end
        taken = fill + 1;
        fill  = taken & 32'h3ff;
        span  = (span_reg == '0) ? 1 : span_reg;
        if (taken >= span) begin
            w.decision = (2 * tally > taken);
            w.count    = 10'(tally);
            bits_due.push_back(w);
            corr_low  = 0;
            corr_high = 0;
            fill      = 0;
            tally     = 0;
        end
    endtask

    task automatic compare_word();
        bit_word_t w;
        if (bits_due.size() == 0) begin
            report_mismatch("result word with nothing expected");
        end else begin
            w = bits_due.pop_front();
            if (m_bit_value !== w.decision) begin
                report_mismatch($sformatf("bit_value %0b, expected %0b",
                                          m_bit_value, w.decision));
            end
            if (m_positive_count !== w.count) begin
                report_mismatch($sformatf("positive_count %0d, expected %0d",
                                          m_positive_count, w.count));
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  = STEP_AT_RESET;
            span_reg  = SPAN_AT_RESET;
            osc_phase = '0;
            corr_low  = 0;
            corr_high = 0;
            fill      = 0;
            tally     = 0;
            bits_due.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    bfsk_pkg::CFG_PHASE_STEP: begin
                        step_reg = cfg_data;
                    end
                    bfsk_pkg::CFG_SAMPLES_PER_BIT: begin
                        span_reg = cfg_data[9:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                compare_word();
            end
            if (s_valid && s_ready) begin
                take_sample(s_sample);
            end
        end
        due_depth <= bits_due.size();
    end

endmodule

/* tb/tb_top.sv */
// top of the bfsk demodulator testbench: clock, reset, sample stimulus and verdict
module tb_top;

    localparam int CYCLE_LIMIT = 400000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    bfsk_pkg::cfg_index_t   cfg_index = bfsk_pkg::CFG_PHASE_STEP;
    logic [15:0]            cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic signed [15:0]     s_sample  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic                   m_bit_value;
    logic [9:0]             m_positive_count;
    int                     words_pending;
    int                     mismatch_count;

    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          cycle_count = 0;
    int          win_span    = 100;
    logic [15:0] gen_phase   = '0;
    logic [15:0] cur_step    = 16'd655;

    always #6 aclk = ~aclk;

    bfsk_correlation_demodulator u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bit_value      (m_bit_value),
        .m_positive_count (m_positive_count)
    );

    bfsk_demod_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_bit_value      (m_bit_value),
        .m_positive_count (m_positive_count),
        .words_pending    (words_pending),
        .mismatch_count   (mismatch_count)
    );

    always @(posedge aclk) begin
        m_ready     <= ($urandom_range(99) >= stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bfsk_correlation_demodulator regression: fail");
            $finish;
        end
    end

    task automatic push_sample(input logic [15:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        gen_phase = gen_phase + cur_step;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input bfsk_pkg::cfg_index_t idx, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [15:0] step, input logic [15:0] span_word);
        settle();
        write_reg(bfsk_pkg::CFG_PHASE_STEP, step);
        write_reg(bfsk_pkg::CFG_SAMPLES_PER_BIT, span_word);
        cur_step = step;
        win_span = (span_word[9:0] == '0) ? 1 : int'(span_word[9:0]);
    endtask

    function automatic logic [15:0] corner_sample();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    // a run of n tone, noise or corner samples, at most one window long
    task automatic feed_window(input int n);
        int          kind;
        int          amp;
        int          noise;
        int          v;
        logic        high_tone;
        logic [15:0] ph;
        kind      = $urandom_range(99);
        amp       = $urandom_range(24000, 500);
        high_tone = 1'($urandom_range(1));
        for (int i = 0; i < n; i++) begin
            if (kind < 70) begin
                ph    = high_tone ? gen_phase * 16'd3 : gen_phase;
                noise = $urandom_range(8000);
                v     = (ph[15] ? -amp : amp) + noise - 4000;
                push_sample(16'(v));
            end else if (kind < 85) begin
                push_sample(16'($urandom));
            end else begin
                push_sample(corner_sample());
            end
        end
    endtask

    initial begin
        int          budget;
        int          n;
        logic [15:0] step;
        logic [9:0]  span;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings, first word sees phase zero
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hffff);
        push_sample(16'h0001);
        // window shortened below the samples already taken
        configure(16'd655, 16'hfc02);
        push_sample(16'h5a5a);
        // zero length window, zero differences
        configure(16'hffff, 16'h0000);
        push_sample(16'h0000);
        push_sample(16'h0000);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'hffff);
        push_sample(16'h0001);
        push_sample(16'h7ffe);
        push_sample(16'h8001);
        configure(16'h4000, 16'h0003);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'h7fff);

        for (int k = 0; k < 12; k++) begin
            case (k % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            if (k == 0) begin
                step = 16'd1;
            end else if (k == 1) begin
                step = 16'hffff;
            end else if ($urandom_range(1)) begin
                step = 16'($urandom_range(4000, 64));
            end else begin
                step = 16'($urandom_range(65535, 1));
            end
            if (k == 2) begin
                span = 10'd1;
            end else if (k == 7) begin
                span = 10'd0;
            end else if (k == 11) begin
                span = 10'd1023;
            end else begin
                span = 10'($urandom_range(24, 2));
            end
            budget = $urandom_range(80, 50);
            if (k == 11) begin
                // close the open window so the long one starts clean
                configure(step, 16'h0001);
                push_sample(corner_sample());
                budget = 1023;
            end
            configure(step, {6'($urandom), span});
            while (budget > 0) begin
                n = win_span;
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(win_span, 1);
                end
                if (n > budget) begin
                    n = budget;
                end
                feed_window(n);
                budget -= n;
            end
        end

        settle();
        if (mismatch_count == 0) begin
            $display("bfsk_correlation_demodulator regression: pass");
        end else begin
            $display("bfsk_correlation_demodulator regression: fail");
        end
        $finish;
    end

endmodule
